// File: rtl/core/scpa_pkg.sv
package scpa_pkg;

	localparam int SIZE_W    = 13;
	localparam int ADDR_W    = 14;
	localparam int OFF_W     = 12;
	localparam int CLS_W     = ADDR_W - OFF_W;
	localparam int SIZE_REGS = 4;
	localparam int CCOUNT_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int DSTEP_W   = $clog2(SIZE_W + 1);
	localparam int FP_W      = 2 * SIZE_W + 1;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ARENA  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CCOUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE3  = 3'd5;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOMATCH  = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_BAD_ADDR = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_DIV,
		S_ALLOC,
		S_POP,
		S_SLOT,
		S_FMUL,
		S_FCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted_address;
	} out_t;

endpackage

// File: rtl/core/size_class_pool_allocator.sv
// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// in       | in_valid, in_ready, in_data (in_t)       | request
// out      | out_valid, out_ready, out_data (out_t)   | result
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Allocate passes through the pop state when it takes a freed slot and skips it when it
// takes the watermark; free runs the 13-step restoring divider; init runs the divider
// once per class in use with a nonzero size, and skips each class in use with a zero size.
// The freed-slot stacks live in one RAM; counts, watermarks and registers reset to zero
// or their defaults, and the RAM is never cleared since only pushed entries are read.
// A finished beat waits in the output register; a new request is taken once the
// previous result has moved there.
module size_class_pool_allocator
	import scpa_pkg::*;
#(
	parameter int MAX_CLASSES     = 4,
	parameter int MAX_ARENA_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int SW    = $clog2(MAX_ARENA_BYTES);
	localparam int NW    = $clog2(MAX_ARENA_BYTES + 1);
	localparam int DEPTH = MAX_CLASSES * MAX_ARENA_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int NLIM  = (MAX_CLASSES < SIZE_REGS) ? MAX_CLASSES : SIZE_REGS;
	localparam int PW    = SW + SIZE_W;

	logic [SIZE_W-1:0]   arena_q;
	logic [CCOUNT_W-1:0] ccount_q;
	logic [SIZE_W-1:0]   size_q [SIZE_REGS];
	logic [NW-1:0]       wm_q [MAX_CLASSES];
	logic [NW-1:0]       cnt_q [MAX_CLASSES];

	state_t              state_q, state_d;
	logic [CLS_W-1:0]    cls_q;
	logic [SIZE_W-1:0]   req_q;
	logic [CCOUNT_W-1:0] icls_q;
	logic                div_init_q;
	logic [DSTEP_W-1:0]  dstep_q;
	logic [SIZE_W-1:0]   rem_q, quo_q, dvs_q;
	logic [SW-1:0]       slot_q;
	logic [FP_W-1:0]     prod_q;
	out_t                res_q, out_q;
	logic                out_valid_q;

	logic [SIZE_W-1:0]   arena_used;
	logic [CCOUNT_W-1:0] n_use;
	logic                hit;
	logic [CLS_W-1:0]    found;
	logic [CLS_W-1:0]    acc_cls;
	logic [OFF_W-1:0]    acc_off;
	logic                pre_bad;
	logic [CW-1:0]       cls_i, icls_i;
	logic [NW-1:0]       cur_cnt, cur_wm;
	logic                init_more, init_zero;
	logic [SIZE_W:0]     trial;
	logic                ge;
	logic [SIZE_W-1:0]   rem_n, quo_n;
	logic                div_last;
	logic                free_bad, free_full;
	logic [PW-1:0]       grant_prod;
	logic                accept, out_load;
	logic [AW-1:0]       mem_base, mem_raddr, mem_waddr;
	logic                mem_we;
	logic [SW-1:0]       mem_wdata, mem_rdata;

	assign arena_used = (32'(arena_q) > MAX_ARENA_BYTES) ? SIZE_W'(MAX_ARENA_BYTES) : arena_q;
	assign n_use      = (ccount_q > CCOUNT_W'(NLIM)) ? CCOUNT_W'(NLIM) : ccount_q;

	always_comb begin
		hit   = 1'b0;
		found = '0;
		for (int c = SIZE_REGS - 1; c >= 0; c--) begin
			if (c < int'(n_use) && size_q[c] == in_data.request_size) begin
				hit   = 1'b1;
				found = CLS_W'(c);
			end
		end
	end

	assign acc_cls = in_data.block_address[ADDR_W-1:OFF_W];
	assign acc_off = in_data.block_address[OFF_W-1:0];
	assign pre_bad = ({1'b0, acc_cls} >= n_use) || ({1'b0, acc_off} >= arena_used) ||
		(size_q[acc_cls] == '0);

	assign cls_i   = CW'(cls_q);
	assign icls_i  = CW'(icls_q);
	assign cur_cnt = cnt_q[cls_i];
	assign cur_wm  = wm_q[cls_i];

	assign init_more = icls_q < n_use;
	assign init_zero = size_q[icls_q[CLS_W-1:0]] == '0;

	assign trial    = {rem_q, quo_q[SIZE_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign rem_n    = ge ? SIZE_W'(trial - {1'b0, dvs_q}) : trial[SIZE_W-1:0];
	assign quo_n    = {quo_q[SIZE_W-2:0], ge};
	assign div_last = dstep_q == DSTEP_W'(SIZE_W - 1);

	assign free_bad   = prod_q > FP_W'(arena_used);
	assign free_full  = cur_cnt >= NW'(MAX_ARENA_BYTES);
	assign grant_prod = PW'(slot_q) * PW'(req_q);

	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign mem_base  = AW'(cls_i) * AW'(MAX_ARENA_BYTES);
	assign mem_raddr = mem_base + AW'(cur_cnt - NW'(1));
	assign mem_waddr = mem_base + AW'(cur_cnt);
	assign mem_we    = (state_q == S_FCHK) && !free_bad && !free_full;
	assign mem_wdata = SW'(quo_q);

	scpa_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_data.opcode)
						OP_INIT:  state_d = S_INIT;
						OP_ALLOC: state_d = hit ? S_ALLOC : S_DONE;
						OP_FREE:  state_d = pre_bad ? S_DONE : S_DIV;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_INIT: begin
				if (!init_more) begin
					state_d = S_DONE;
				end else if (!init_zero) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_last) begin
					state_d = div_init_q ? S_INIT : S_FMUL;
				end
			end
			S_ALLOC: begin
				if (cur_cnt != '0) begin
					state_d = S_POP;
				end else if (cur_wm != '0) begin
					state_d = S_SLOT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP:  state_d = S_SLOT;
			S_SLOT: state_d = S_DONE;
			S_FMUL: state_d = S_FCHK;
			S_FCHK: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q     <= SIZE_W'(4096);
			ccount_q    <= CCOUNT_W'(4);
			size_q[0]   <= SIZE_W'(16);
			size_q[1]   <= SIZE_W'(32);
			size_q[2]   <= SIZE_W'(64);
			size_q[3]   <= SIZE_W'(128);
			for (int i = 0; i < MAX_CLASSES; i++) begin
				wm_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
			icls_q      <= '0;
			div_init_q  <= 1'b0;
			dstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ARENA:  arena_q   <= cfg_data;
					CFG_CCOUNT: ccount_q  <= cfg_data[CCOUNT_W-1:0];
					CFG_SIZE0:  size_q[0] <= cfg_data;
					CFG_SIZE1:  size_q[1] <= cfg_data;
					CFG_SIZE2:  size_q[2] <= cfg_data;
					CFG_SIZE3:  size_q[3] <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					dstep_q <= '0;
					if (accept && in_data.opcode == OP_INIT) begin
						for (int i = 0; i < MAX_CLASSES; i++) begin
							wm_q[i]  <= '0;
							cnt_q[i] <= '0;
						end
						icls_q <= '0;
					end
					if (accept && in_data.opcode == OP_FREE) begin
						div_init_q <= 1'b0;
					end
				end
				S_INIT: begin
					dstep_q <= '0;
					if (init_more) begin
						if (init_zero) begin
							icls_q <= icls_q + CCOUNT_W'(1);
						end else begin
							div_init_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					dstep_q <= dstep_q + DSTEP_W'(1);
					if (div_last && div_init_q) begin
						wm_q[icls_i] <= NW'(quo_n);
						icls_q       <= icls_q + CCOUNT_W'(1);
					end
				end
				S_ALLOC: begin
					if (cur_cnt != '0) begin
						cnt_q[cls_i] <= cur_cnt - NW'(1);
					end else if (cur_wm != '0) begin
						wm_q[cls_i] <= cur_wm - NW'(1);
					end
				end
				S_FCHK: begin
					if (mem_we) begin
						cnt_q[cls_i] <= cur_cnt + NW'(1);
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cls_q                 <= in_data.opcode == OP_FREE ? acc_cls : found;
					req_q                 <= in_data.request_size;
					res_q.granted_address <= '0;
					rem_q                 <= '0;
					quo_q                 <= {1'b0, acc_off};
					dvs_q                 <= size_q[acc_cls];
					if (in_data.opcode == OP_ALLOC && !hit) begin
						res_q.status <= ST_NOMATCH;
					end else if (in_data.opcode == OP_FREE && pre_bad) begin
						res_q.status <= ST_BAD_ADDR;
					end else begin
						res_q.status <= ST_OK;
					end
				end
			end
			S_INIT: begin
				rem_q <= '0;
				quo_q <= arena_used;
				dvs_q <= size_q[icls_q[CLS_W-1:0]];
			end
			S_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
			S_ALLOC: begin
				slot_q <= SW'(cur_wm - NW'(1));
				if (cur_cnt == '0 && cur_wm == '0) begin
					res_q.status <= ST_EXHAUSTED;
				end
			end
			S_POP: slot_q <= mem_rdata;
			S_SLOT: begin
				res_q.granted_address <= {cls_q, {OFF_W{1'b0}}} + grant_prod[ADDR_W-1:0];
			end
			S_FMUL: begin
				prod_q <= FP_W'({1'b0, quo_q} + (SIZE_W + 1)'(1)) * FP_W'(dvs_q);
			end
			S_FCHK: begin
				if (free_bad) begin
					res_q.status <= ST_BAD_ADDR;
				end else if (free_full) begin
					res_q.status <= ST_FULL;
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dvs_q != '0)
		else $error("divider running with a zero block size");

	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> $past(state_q) == S_ALLOC)
		else $error("stack read without an allocate decision");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted request produced no work");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> cur_cnt < NW'(MAX_ARENA_BYTES))
		else $error("push into a full freed-slot stack");

endmodule

// File: rtl/core/scpa_ram.sv
module scpa_ram
	import scpa_pkg::*;
#(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: test/pool_grant_checker.sv
`timescale 1ns / 1ps

module pool_grant_checker
	import scpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_t                  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_t                 out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	output int                   open_replies,
	output int                   miss_count
);

	localparam int POOL_CLASSES = 4;
	localparam int ARENA_CAP    = 4096;
	localparam int STACK_DEPTH  = 4096;
	localparam int CLASS_SPAN   = 1 << OFF_W;

	logic [SIZE_W-1:0]   arena_q;
	logic [CCOUNT_W-1:0] count_q;
	logic [SIZE_W-1:0]   size_q [SIZE_REGS];
	int unsigned         watermark [POOL_CLASSES];
	int unsigned         depth [POOL_CLASSES];
	logic [OFF_W-1:0]    freed_slots [POOL_CLASSES][STACK_DEPTH];
	out_t                grant_queue [$];
	out_t                want;
	int                  misses;

	function automatic int unsigned arena_eff();
		return (arena_q > ARENA_CAP) ? ARENA_CAP : arena_q;
	endfunction

	function automatic int unsigned blocks_in(int unsigned c);
		return (size_q[c] == 0) ? 0 : arena_eff() / size_q[c];
	endfunction

	// Applies one request to the shadow pools and returns the answer it must produce.
	function automatic out_t serve_request(in_t req);
		out_t        r;
		int unsigned n;
		int unsigned found;
		int unsigned slot;
		int unsigned cls;
		int unsigned off;
		int unsigned addr;
		r.status = ST_OK;
		r.granted_address = '0;
		n = (count_q > POOL_CLASSES) ? POOL_CLASSES : count_q;
		case (req.opcode)
			OP_INIT: begin
				for (int unsigned c = 0; c < POOL_CLASSES; c++) begin
					watermark[c] = (c < n) ? blocks_in(c) : 0;
					depth[c] = 0;
				end
			end
			OP_ALLOC: begin
				found = n;
				for (int unsigned c = 0; c < n; c++) begin
					if (found == n && size_q[c] == req.request_size) found = c;
				end
				if (found == n) begin
					r.status = ST_NOMATCH;
				end else if (depth[found] == 0 && watermark[found] == 0) begin
					r.status = ST_EXHAUSTED;
				end else begin
					if (depth[found] != 0) begin
						depth[found] = depth[found] - 1;
						slot = freed_slots[found][depth[found]];
					end else begin
						watermark[found] = watermark[found] - 1;
						slot = watermark[found];
					end
					addr = found * CLASS_SPAN + slot * req.request_size;
					r.granted_address = addr[ADDR_W-1:0];
				end
			end
			OP_FREE: begin
				cls = req.block_address[ADDR_W-1:OFF_W];
				off = req.block_address[OFF_W-1:0];
				if (cls >= n || off >= arena_eff() || size_q[cls] == 0) begin
					r.status = ST_BAD_ADDR;
				end else if (off / size_q[cls] >= blocks_in(cls)) begin
					r.status = ST_BAD_ADDR;
				end else if (depth[cls] >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					freed_slots[cls][depth[cls]] = off / size_q[cls];
					depth[cls] = depth[cls] + 1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q = 13'd4096;
			count_q = 3'd4;
			size_q = '{13'd16, 13'd32, 13'd64, 13'd128};
			for (int c = 0; c < POOL_CLASSES; c++) begin
				watermark[c] = 0;
				depth[c] = 0;
			end
			grant_queue.delete();
			misses = 0;
			open_replies <= 0;
			miss_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ARENA:  arena_q = cfg_data;
					CFG_CCOUNT: count_q = cfg_data[CCOUNT_W-1:0];
					CFG_SIZE0:  size_q[0] = cfg_data;
					CFG_SIZE1:  size_q[1] = cfg_data;
					CFG_SIZE2:  size_q[2] = cfg_data;
					CFG_SIZE3:  size_q[3] = cfg_data;
					default: begin
					end
				endcase
			end
			// A result beat can never belong to a request taken on the same edge.
			if (out_valid && out_ready) begin
				if (grant_queue.size() == 0) begin
					if (misses < 10)
						$display("unexpected result beat: status %0d address %0d",
							out_data.status, out_data.granted_address);
					misses++;
				end else begin
					want = grant_queue.pop_front();
					if (want.status !== out_data.status ||
						want.granted_address !== out_data.granted_address) begin
						if (misses < 10)
							$display("mismatch: status exp %0d got %0d, address exp %0d got %0d",
								want.status, out_data.status,
								want.granted_address, out_data.granted_address);
						misses++;
					end
				end
			end
			if (in_valid && in_ready) grant_queue = {grant_queue, serve_request(in_data)};
			open_replies <= grant_queue.size();
			miss_count <= misses;
		end
	end

endmodule

// File: test/size_class_pool_allocator_tb.sv
`timescale 1ns / 1ps

module size_class_pool_allocator_tb;
	import scpa_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 145;
	localparam int TAIL_CYCLES   = 60;
	localparam int ARENA_CAP     = 4096;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data = '0;

	int          open_replies;
	int          miss_count;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_asked = 0;
	int          hold_given = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int unsigned pool_arena = 4096;
	int unsigned pool_count = 4;
	int unsigned pool_size [SIZE_REGS] = '{16, 32, 64, 128};

	size_class_pool_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pool_grant_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.open_replies (open_replies),
		.miss_count   (miss_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A requested hold-off keeps the result channel closed for a long stretch.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			hold_given <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic int unsigned live_classes();
		return (pool_count > SIZE_REGS) ? SIZE_REGS : pool_count;
	endfunction

	function automatic int unsigned blocks_in(int unsigned c);
		int unsigned arena;
		arena = (pool_arena > ARENA_CAP) ? ARENA_CAP : pool_arena;
		return (pool_size[c] == 0) ? 0 : arena / pool_size[c];
	endfunction

	function automatic int unsigned extreme_value();
		case ($urandom_range(3))
			0: return 0;
			1: return 1;
			2: return 4096;
			default: return 8191;
		endcase
	endfunction

	task automatic issue(input logic [1:0] op, input int unsigned size, input int unsigned addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{op, size[SIZE_W-1:0], addr[ADDR_W-1:0]};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_replies != 0) @(posedge clk);
	endtask

	task automatic program_pool(input int unsigned arena, count, s0, s1, s2, s3);
		logic [CFG_IDX_W-1:0] regs [6];
		int unsigned          vals [6];
		regs = '{CFG_ARENA, CFG_CCOUNT, CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3};
		vals = '{arena, count, s0, s1, s2, s3};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][SIZE_W-1:0];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		pool_arena = arena & 32'h1FFF;
		pool_count = count & 32'h7;
		pool_size = '{s0 & 32'h1FFF, s1 & 32'h1FFF, s2 & 32'h1FFF, s3 & 32'h1FFF};
	endtask

	task automatic pick_setting();
		int unsigned arena;
		int unsigned count;
		int unsigned sz [SIZE_REGS];
		int unsigned roll;
		arena = ($urandom_range(7) == 0) ? extreme_value() : $urandom_range(600, 1);
		count = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
		for (int c = 0; c < SIZE_REGS; c++) begin
			roll = $urandom_range(99);
			if (roll < 10)
				sz[c] = extreme_value();
			else if (roll < 20 && c > 0)
				sz[c] = sz[c-1];
			else
				sz[c] = $urandom_range(48, 1);
		end
		program_pool(arena, count, sz[0], sz[1], sz[2], sz[3]);
	endtask

	// Mostly allocations of live sizes and frees of real blocks, with some noise.
	task automatic random_request();
		int unsigned n;
		int unsigned c;
		int unsigned roll;
		int unsigned off;
		n = live_classes();
		c = (n == 0) ? 0 : $urandom_range(n - 1);
		roll = $urandom_range(99);
		if (roll < 45 && n != 0) begin
			issue(OP_ALLOC, pool_size[c], $urandom_range(16383));
		end else if (roll < 80 && n != 0 && blocks_in(c) != 0) begin
			off = $urandom_range(blocks_in(c) - 1) * pool_size[c];
			if ($urandom_range(3) == 0) off = off + $urandom_range(pool_size[c] - 1);
			issue(OP_FREE, $urandom_range(8191), c * 4096 + off);
		end else if (roll < 84) begin
			issue(OP_INIT, $urandom_range(8191), $urandom_range(16383));
		end else if (roll < 90) begin
			issue(OP_ALLOC, $urandom_range(8191), $urandom_range(16383));
		end else if (roll < 96) begin
			issue(OP_FREE, $urandom_range(8191), $urandom_range(16383));
		end else begin
			issue(OP_NONE, $urandom_range(8191), $urandom_range(16383));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default pools, before and after the first init.
		issue(OP_ALLOC, 16, 0);
		issue(OP_FREE, 0, 0);
		issue(OP_ALLOC, 16, 16383);
		issue(OP_NONE, 8191, 16383);
		issue(OP_INIT, 0, 0);
		issue(OP_ALLOC, 16, 0);
		issue(OP_ALLOC, 128, 0);
		issue(OP_ALLOC, 20, 0);
		issue(OP_ALLOC, 8191, 0);
		issue(OP_ALLOC, 0, 0);
		issue(OP_FREE, 0, 16383);
		issue(OP_ALLOC, 128, 0);
		issue(OP_FREE, 0, 4080);
		issue(OP_FREE, 0, 4080);

		quiesce();
		program_pool(4096, 0, 16, 32, 64, 128);
		issue(OP_ALLOC, 16, 0);
		issue(OP_FREE, 0, 0);

		quiesce();
		program_pool(8191, 7, 16, 16, 4096, 0);
		issue(OP_INIT, 0, 0);
		issue(OP_ALLOC, 16, 0);
		issue(OP_ALLOC, 4096, 0);
		issue(OP_ALLOC, 0, 0);
		issue(OP_FREE, 0, 12288);

		quiesce();
		program_pool(100, 4, 30, 8191, 1, 2);
		issue(OP_INIT, 0, 0);
		issue(OP_FREE, 0, 95);
		issue(OP_FREE, 0, 100);
		issue(OP_ALLOC, 8191, 0);

		// Size changed without a new init; the address wraps.
		quiesce();
		program_pool(100, 4, 30, 8191, 1, 4000);
		issue(OP_ALLOC, 4000, 0);

		// Push one slot several times over, then pop it back three times and free it once more.
		quiesce();
		program_pool(16, 1, 16, 32, 64, 128);
		issue(OP_INIT, 0, 0);
		for (int i = 0; i < 8; i++) issue(OP_FREE, 0, 0);
		issue(OP_ALLOC, 16, 0);
		issue(OP_ALLOC, 16, 0);
		issue(OP_ALLOC, 16, 0);
		issue(OP_FREE, 0, 0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			quiesce();
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			pick_setting();
			if (phase == 1) hold_asked = hold_asked + 1;
			issue(OP_INIT, 0, 0);
			for (int k = 0; k < PHASE_ITEMS; k++) random_request();
		end

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (miss_count == 0 && open_replies == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/scpa_pkg.sv
rtl/core/scpa_ram.sv
rtl/core/size_class_pool_allocator.sv
test/pool_grant_checker.sv
test/size_class_pool_allocator_tb.sv
